@@ design/bbhf_pkg.sv @@
// Shared types, sizes and helpers for the box blur / hole fill filter.
// No dependencies; the front end, back end and core import this package.
`default_nettype none

package bbhf_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_RAYS    = 512;
    localparam int MAX_KERNEL  = 15;
    localparam int RING_ROWS   = MAX_KERNEL + 3;

    localparam int ROW_W  = $clog2(MAX_RAYS);
    localparam int RCNT_W = $clog2(MAX_RAYS + 1);
    localparam int COL_W  = $clog2(MAX_SAMPLES);
    localparam int SCNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int KER_W  = $clog2(MAX_KERNEL + 1);
    localparam int SLOT_W = $clog2(RING_ROWS);
    localparam int ADDR_W = $clog2(RING_ROWS * MAX_SAMPLES);
    localparam int AREA_W = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int SUM_W  = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
    localparam int NUM_W  = SUM_W + 1;
    localparam int DEN_W  = AREA_W + 1;

    localparam logic [2:0] REG_FILTER_MODE  = 3'd0;
    localparam logic [2:0] REG_RAY_COUNT    = 3'd1;
    localparam logic [2:0] REG_SAMPLES      = 3'd2;
    localparam logic [2:0] REG_AXIAL_KER    = 3'd3;
    localparam logic [2:0] REG_LATERAL_KER  = 3'd4;
    localparam logic [2:0] REG_AXIAL_THR    = 3'd5;
    localparam logic [2:0] REG_LATERAL_THR  = 3'd6;
    localparam logic [2:0] REG_HOLE_ALPHA   = 3'd7;

    // blur centers visited per result
    localparam logic [2:0] CTR_MID   = 3'd0;
    localparam logic [2:0] CTR_UP    = 3'd1;
    localparam logic [2:0] CTR_DOWN  = 3'd2;
    localparam logic [2:0] CTR_LEFT  = 3'd3;
    localparam logic [2:0] CTR_RIGHT = 3'd4;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ADDR,
        B_DRAIN,
        B_DIV,
        B_NEXT,
        B_FILL,
        B_OUT
    } t_bstate;

    // effective (clamped) configuration
    typedef struct packed {
        logic                    filter;
        logic [RCNT_W-1:0]       rays;
        logic [SCNT_W-1:0]       samples;
        logic [KER_W-1:0]        ka;
        logic [KER_W-1:0]        kl;
        logic [AREA_W-1:0]       area;
        logic signed [8:0]       thr_ax;
        logic signed [8:0]       thr_lat;
        logic [8:0]              alpha;
    } t_cfg;

    typedef struct packed {
        logic                    bypass;
        logic [7:0]              pixel;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic [SLOT_W-1:0]       slot;
        logic                    interior;
        logic                    last;
    } t_job;

    typedef struct packed {
        logic [7:0]              pixel;
        logic                    last;
    } t_res;

    typedef struct packed {
        logic                    en;
        logic [ADDR_W-1:0]       addr;
        logic [7:0]              data;
    } t_wr;

    typedef struct packed {
        logic                    done;
        logic                    last;
    } t_done;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(RING_ROWS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ design/bbhf_fifo.sv @@
// Small synchronous FIFO used for the job queue and the result queue.
// Standalone, no package dependency.
`default_nettype none

module bbhf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr, rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        n_cnt = r_cnt + CW'(wr) - CW'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ design/bbhf_front.sv @@
// Front end: accepts items, tracks input/output raster positions, writes the
// line store and issues one job per due result. Depends on bbhf_pkg.
`default_nettype none

module bbhf_front
    import bbhf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_restart,
    input  wire logic       i_push,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_pixel,
    output logic            o_full,
    output t_wr             o_wr,
    output t_job            o_job,
    output logic            o_job_push,
    input  wire t_done      i_done
);

    logic [RCNT_W-1:0] r_in_row, n_in_row;
    logic [COL_W-1:0]  r_in_col, n_in_col;
    logic [SLOT_W-1:0] r_in_slot, n_in_slot;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [1:0]        r_pend, n_pend;
    logic              r_last_pend, n_last_pend;

    logic              acc, in_done, wr_px, issue_f, issue_b, last_f, last_b;
    logic [SCNT_W-1:0] col_inc;
    logic              col_wrap;
    logic [RCNT_W-1:0] pos_row;
    logic [COL_W-1:0]  pos_col;
    logic [SLOT_W-1:0] pos_slot;
    logic [RCNT_W-1:0] rmax, rr_t, rr, a;
    logic [RCNT_W:0]   a_t;
    logic [SCNT_W-1:0] smax, cc_t, cc, b;
    logic [SCNT_W:0]   b_t;
    logic [KER_W-1:0]  dn, dr;
    logic [SCNT_W-1:0] ocol_inc;
    logic              ready, interior;

    // a pending result still reads ring rows, so hold input back
    assign o_full = (r_pend >= 2'd2) || r_last_pend;
    assign acc    = i_push && !o_full;

    assign in_done  = (r_in_row == i_cfg.rays);
    assign wr_px    = acc && i_cfg.filter && !i_req_type && !in_done;
    assign col_inc  = SCNT_W'(r_in_col) + SCNT_W'(1);
    assign col_wrap = (col_inc == i_cfg.samples);

    always_comb begin
        pos_row  = r_in_row;
        pos_col  = r_in_col;
        pos_slot = r_in_slot;
        if (acc && !i_req_type && (wr_px || !i_cfg.filter)) begin
            if (col_wrap) begin
                pos_row  = r_in_row + RCNT_W'(1);
                pos_col  = '0;
                pos_slot = next_slot(r_in_slot);
            end else begin
                pos_col  = col_inc[COL_W-1:0];
            end
        end
    end

    // readiness: last input the result depends on
    assign rmax = i_cfg.rays - RCNT_W'(1);
    assign smax = i_cfg.samples - SCNT_W'(1);
    assign dn   = i_cfg.kl - KER_W'(1) - (i_cfg.kl >> 1);
    assign dr   = i_cfg.ka - KER_W'(1) - (i_cfg.ka >> 1);
    assign rr_t = RCNT_W'(r_out_row) + RCNT_W'(1);
    assign rr   = (rr_t < i_cfg.rays) ? rr_t : rmax;
    assign a_t  = (RCNT_W + 1)'(rr) + (RCNT_W + 1)'(dn);
    assign a    = (a_t > (RCNT_W + 1)'(rmax)) ? rmax : a_t[RCNT_W-1:0];
    assign cc_t = SCNT_W'(r_out_col) + SCNT_W'(1);
    assign cc   = (cc_t < i_cfg.samples) ? cc_t : smax;
    assign b_t  = (SCNT_W + 1)'(cc) + (SCNT_W + 1)'(dr);
    assign b    = (b_t > (SCNT_W + 1)'(smax)) ? smax : b_t[SCNT_W-1:0];

    assign ready = (a < pos_row) || ((a == pos_row) && (b < SCNT_W'(pos_col)));

    assign issue_f  = acc && i_cfg.filter && ready;
    assign issue_b  = acc && !i_cfg.filter && !i_req_type;
    assign last_f   = (RCNT_W'(r_out_row) == rmax) && (SCNT_W'(r_out_col) == smax);
    assign last_b   = (pos_row == i_cfg.rays);
    assign ocol_inc = SCNT_W'(r_out_col) + SCNT_W'(1);
    assign interior = (r_out_row != '0) && (RCNT_W'(r_out_row) != rmax) &&
                      (r_out_col != '0) && (SCNT_W'(r_out_col) != smax);

    assign o_wr.en   = wr_px;
    assign o_wr.addr = ADDR_W'(r_in_slot) * ADDR_W'(MAX_SAMPLES) + ADDR_W'(r_in_col);
    assign o_wr.data = i_pixel;

    assign o_job_push     = issue_f || issue_b;
    assign o_job.bypass   = !i_cfg.filter;
    assign o_job.pixel    = i_pixel;
    assign o_job.row      = r_out_row;
    assign o_job.col      = r_out_col;
    assign o_job.slot     = r_out_slot;
    assign o_job.interior = interior;
    assign o_job.last     = i_cfg.filter ? last_f : last_b;

    always_comb begin
        n_in_row    = pos_row;
        n_in_col    = pos_col;
        n_in_slot   = pos_slot;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_slot  = r_out_slot;
        n_pend      = r_pend + 2'(o_job_push) - 2'(i_done.done);
        n_last_pend = r_last_pend;
        if (i_done.done && i_done.last) begin
            n_last_pend = 1'b0;
        end
        if (issue_f) begin
            if (last_f) begin
                n_in_row    = '0;
                n_in_col    = '0;
                n_in_slot   = '0;
                n_out_row   = '0;
                n_out_col   = '0;
                n_out_slot  = '0;
                n_last_pend = 1'b1;
            end else if (ocol_inc == i_cfg.samples) begin
                n_out_row   = r_out_row + ROW_W'(1);
                n_out_col   = '0;
                n_out_slot  = next_slot(r_out_slot);
            end else begin
                n_out_col   = ocol_inc[COL_W-1:0];
            end
        end
        if (issue_b && last_b) begin
            n_in_row  = '0;
            n_in_col  = '0;
            n_in_slot = '0;
        end
        if (i_restart) begin
            n_in_row   = '0;
            n_in_col   = '0;
            n_in_slot  = '0;
            n_out_row  = '0;
            n_out_col  = '0;
            n_out_slot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_in_slot   <= '0;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_slot  <= '0;
            r_pend      <= '0;
            r_last_pend <= 1'b0;
        end else begin
            r_in_row    <= n_in_row;
            r_in_col    <= n_in_col;
            r_in_slot   <= n_in_slot;
            r_out_row   <= n_out_row;
            r_out_col   <= n_out_col;
            r_out_slot  <= n_out_slot;
            r_pend      <= n_pend;
            r_last_pend <= n_last_pend;
        end
    end

endmodule

`default_nettype wire

@@ design/bbhf_back.sv @@
// Back end: holds the ring line store, blurs up to five centers per job with
// one read a cycle and a serial divider, then applies hole fill. Uses bbhf_pkg.
`default_nettype none

module bbhf_back
    import bbhf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire t_wr  i_wr,
    input  wire t_job i_job,
    input  wire logic i_job_empty,
    output logic      o_job_pop,
    input  wire logic i_res_full,
    output t_res      o_res,
    output logic      o_res_push,
    output t_done     o_done
);

    localparam int YW     = ROW_W + 2;
    localparam int XW     = COL_W + 2;
    localparam int DIV_CW = $clog2(NUM_W);

    logic [7:0] r_mem [RING_ROWS * MAX_SAMPLES];

    t_bstate            r_state, n_state;
    t_job               r_job;
    logic [2:0]         r_k;
    logic [KER_W-1:0]   r_dy, r_dx;
    logic [SUM_W-1:0]   r_sum;
    logic               r_rd_vld;
    logic [7:0]         r_rd_data;
    logic [DIV_CW-1:0]  r_div_cnt;
    logic [DEN_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_quo;
    logic [7:0]         r_bv [5];
    logic [7:0]         r_res;

    logic               rd_en, loop_end, div_end, last_ctr;
    logic signed [YW-1:0] ci, y, st;
    logic signed [XW-1:0] cj, x;
    logic [ROW_W-1:0]   rmax, yc;
    logic [COL_W-1:0]   smax, xc;
    logic [KER_W-1:0]   du, dl;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  rd_addr;

    logic [NUM_W-1:0]   num, q_src;
    logic [DEN_W-1:0]   den, rem_src, rem_n;
    logic [DEN_W:0]     rem_sh;
    logic               ge;

    logic [8:0]         lat_s, ax_s, w;
    logic signed [10:0] lat, ax, h, v, diff;
    logic [18:0]        prod, prod_r;
    logic [10:0]        tot;
    logic [7:0]         fill;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_job_empty) n_state = i_job.bypass ? B_OUT : B_ADDR;
            B_ADDR:  if (loop_end) n_state = B_DRAIN;
            B_DRAIN: n_state = B_DIV;
            B_DIV:   if (div_end) n_state = B_NEXT;
            B_NEXT:  n_state = last_ctr ? B_FILL : B_ADDR;
            B_FILL:  n_state = B_OUT;
            B_OUT:   if (!i_res_full) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // state decoded controls
    always_comb begin
        rd_en      = 1'b0;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            B_IDLE:  o_job_pop  = !i_job_empty;
            B_ADDR:  rd_en      = 1'b1;
            B_OUT:   o_res_push = !i_res_full;
            default: ;
        endcase
    end

    assign loop_end = (r_dx == i_cfg.ka - KER_W'(1)) && (r_dy == i_cfg.kl - KER_W'(1));
    assign div_end  = (r_div_cnt == DIV_CW'(NUM_W - 1));
    assign last_ctr = (r_k == CTR_RIGHT) || !r_job.interior;

    // window address of the current tap, replicated borders
    assign du   = i_cfg.kl >> 1;
    assign dl   = i_cfg.ka >> 1;
    assign rmax = ROW_W'(i_cfg.rays - RCNT_W'(1));
    assign smax = COL_W'(i_cfg.samples - SCNT_W'(1));

    always_comb begin
        ci = '0;
        cj = '0;
        if (r_k == CTR_UP)    ci = -YW'(1);
        if (r_k == CTR_DOWN)  ci = YW'(1);
        if (r_k == CTR_LEFT)  cj = -XW'(1);
        if (r_k == CTR_RIGHT) cj = XW'(1);
    end

    assign y = $signed({2'b00, r_job.row}) + ci - $signed({(YW - KER_W)'(0), du})
             + $signed({(YW - KER_W)'(0), r_dy});
    assign x = $signed({2'b00, r_job.col}) + cj - $signed({(XW - KER_W)'(0), dl})
             + $signed({(XW - KER_W)'(0), r_dx});

    always_comb begin
        if (y < 0) begin
            yc = '0;
        end else if (y > $signed({2'b00, rmax})) begin
            yc = rmax;
        end else begin
            yc = y[ROW_W-1:0];
        end
        if (x < 0) begin
            xc = '0;
        end else if (x > $signed({2'b00, smax})) begin
            xc = smax;
        end else begin
            xc = x[COL_W-1:0];
        end
        // ring slot of the clamped row, relative to the job's own row
        st = $signed({(YW - SLOT_W)'(0), r_job.slot}) + $signed({2'b00, yc})
           - $signed({2'b00, r_job.row});
        if (st < 0) begin
            st = st + YW'(RING_ROWS);
        end else if (st >= $signed(YW'(RING_ROWS))) begin
            st = st - YW'(RING_ROWS);
        end
        slot = st[SLOT_W-1:0];
    end

    assign rd_addr = ADDR_W'(slot) * ADDR_W'(MAX_SAMPLES) + ADDR_W'(xc);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // restoring divide: (2*sum + n) / (2*n), one quotient bit a cycle
    assign num     = {r_sum, 1'b0} + NUM_W'(i_cfg.area);
    assign den     = {i_cfg.area, 1'b0};
    assign q_src   = (r_div_cnt == '0) ? num : r_quo;
    assign rem_src = (r_div_cnt == '0) ? '0 : r_rem;
    assign rem_sh  = {rem_src, q_src[NUM_W-1]};
    assign ge      = (rem_sh >= (DEN_W + 1)'(den));
    assign rem_n   = ge ? DEN_W'(rem_sh - (DEN_W + 1)'(den)) : rem_sh[DEN_W-1:0];

    // hole fill from the five blurred values
    assign lat_s  = {1'b0, r_bv[CTR_UP]} + {1'b0, r_bv[CTR_DOWN]} + 9'd1;
    assign ax_s   = {1'b0, r_bv[CTR_LEFT]} + {1'b0, r_bv[CTR_RIGHT]} + 9'd1;
    assign lat    = $signed({3'b000, lat_s[8:1]}) - $signed({{2{i_cfg.thr_lat[8]}}, i_cfg.thr_lat});
    assign ax     = $signed({3'b000, ax_s[8:1]}) - $signed({{2{i_cfg.thr_ax[8]}}, i_cfg.thr_ax});
    assign h      = (ax >= lat) ? ax : lat;
    assign v      = $signed({3'b000, r_bv[CTR_MID]});
    assign diff   = h - v;
    assign w      = 9'h100 - i_cfg.alpha;
    assign prod   = {10'b0, w} * {9'b0, diff[9:0]};
    assign prod_r = prod + 19'd128;
    assign tot    = {3'b000, r_bv[CTR_MID]} + prod_r[18:8];
    assign fill   = (r_job.interior && (h > v)) ?
                    ((tot > 11'd255) ? 8'hFF : tot[7:0]) : r_bv[CTR_MID];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_sum <= r_sum + SUM_W'(r_rd_data);
        end
        unique case (r_state)
            B_IDLE: begin
                if (!i_job_empty) begin
                    r_job <= i_job;
                    r_res <= i_job.pixel;
                    r_k   <= CTR_MID;
                    r_dx  <= '0;
                    r_dy  <= '0;
                    r_sum <= '0;
                end
            end
            B_ADDR: begin
                if (r_dx == i_cfg.ka - KER_W'(1)) begin
                    r_dx <= '0;
                    r_dy <= r_dy + KER_W'(1);
                end else begin
                    r_dx <= r_dx + KER_W'(1);
                end
            end
            B_DRAIN: r_div_cnt <= '0;
            B_DIV: begin
                r_rem     <= rem_n;
                r_quo     <= {q_src[NUM_W-2:0], ge};
                r_div_cnt <= r_div_cnt + DIV_CW'(1);
            end
            B_NEXT: begin
                r_bv[r_k] <= r_quo[7:0];
                r_k       <= r_k + 3'd1;
                r_dx      <= '0;
                r_dy      <= '0;
                r_sum     <= '0;
            end
            B_FILL:  r_res <= fill;
            B_OUT:   ;
            default: ;
        endcase
    end

    assign o_res.pixel = r_res;
    assign o_res.last  = r_job.last;
    assign o_done.done = o_res_push;
    assign o_done.last = r_job.last;

endmodule

`default_nettype wire

@@ design/box_blur_hole_fill_filter_core.sv @@
// Box blur and hole fill filter for 8-bit ultrasound frames in raster order.
// Bypass mode passes each pixel through to the result ports. Filter
// mode writes pixels into an 18-row ring line store as they arrive; each due
// result is then computed by a back end that reads that store one sample a cycle
// through a single read port and divides serially. Input items are taken one a
// cycle while fewer than two results are in work, and after the frame's last
// result is issued input holds until that result is done. Reads of the store
// beyond what the frame has written are undefined; no clearing pass is run.
// Any register write restarts the frame.
`default_nettype none

module box_blur_hole_fill_filter_core
    import bbhf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_pixel_in,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_pixel_out,
    output logic             o_frame_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        r_filter_mode;
    logic [9:0]  r_ray_count;
    logic [10:0] r_samples;
    logic [3:0]  r_ka, r_kl;
    logic [8:0]  r_thr_ax, r_thr_lat, r_alpha;

    logic        cfg_wr;
    logic [2:0]  idx;
    t_cfg        cfg;
    t_wr         wr;
    t_job        job_in, job_out;
    logic        job_push, job_pop, job_full, job_empty;
    t_res        res_in, res_out;
    logic        res_push, res_full;
    t_done       done;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= 1'b0;
            r_ray_count   <= 10'd256;
            r_samples     <= 11'd512;
            r_ka          <= 4'd3;
            r_kl          <= 4'd3;
            r_thr_ax      <= '0;
            r_thr_lat     <= '0;
            r_alpha       <= '0;
        end else if (cfg_wr) begin
            unique case (idx)
                REG_FILTER_MODE: r_filter_mode <= pwdata[0];
                REG_RAY_COUNT:   r_ray_count   <= pwdata[9:0];
                REG_SAMPLES:     r_samples     <= pwdata[10:0];
                REG_AXIAL_KER:   r_ka          <= pwdata[3:0];
                REG_LATERAL_KER: r_kl          <= pwdata[3:0];
                REG_AXIAL_THR:   r_thr_ax      <= pwdata[8:0];
                REG_LATERAL_THR: r_thr_lat     <= pwdata[8:0];
                REG_HOLE_ALPHA:  r_alpha       <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FILTER_MODE: prdata = 32'(r_filter_mode);
            REG_RAY_COUNT:   prdata = 32'(r_ray_count);
            REG_SAMPLES:     prdata = 32'(r_samples);
            REG_AXIAL_KER:   prdata = 32'(r_ka);
            REG_LATERAL_KER: prdata = 32'(r_kl);
            REG_AXIAL_THR:   prdata = 32'(r_thr_ax);
            REG_LATERAL_THR: prdata = 32'(r_thr_lat);
            REG_HOLE_ALPHA:  prdata = 32'(r_alpha);
            default:         prdata = '0;
        endcase
    end

    // effective geometry and weights
    always_comb begin
        cfg.filter = r_filter_mode;
        if (RCNT_W'(r_ray_count) < RCNT_W'(3)) begin
            cfg.rays = RCNT_W'(3);
        end else if (RCNT_W'(r_ray_count) > RCNT_W'(MAX_RAYS)) begin
            cfg.rays = RCNT_W'(MAX_RAYS);
        end else begin
            cfg.rays = RCNT_W'(r_ray_count);
        end
        if (SCNT_W'(r_samples) < SCNT_W'(3)) begin
            cfg.samples = SCNT_W'(3);
        end else if (SCNT_W'(r_samples) > SCNT_W'(MAX_SAMPLES)) begin
            cfg.samples = SCNT_W'(MAX_SAMPLES);
        end else begin
            cfg.samples = SCNT_W'(r_samples);
        end
        cfg.ka = (r_ka == '0) ? KER_W'(1) :
                 ((KER_W'(r_ka) > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : KER_W'(r_ka));
        cfg.kl = (r_kl == '0) ? KER_W'(1) :
                 ((KER_W'(r_kl) > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : KER_W'(r_kl));
        cfg.area    = AREA_W'(cfg.ka) * AREA_W'(cfg.kl);
        cfg.thr_ax  = $signed(r_thr_ax);
        cfg.thr_lat = $signed(r_thr_lat);
        cfg.alpha   = (r_alpha > 9'h100) ? 9'h100 : r_alpha;
    end

    bbhf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_restart  (cfg_wr),
        .i_push     (push),
        .i_req_type (i_req_type),
        .i_pixel    (i_pixel_in),
        .o_full     (full),
        .o_wr       (wr),
        .o_job      (job_in),
        .o_job_push (job_push),
        .i_done     (done)
    );

    bbhf_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    bbhf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_wr        (wr),
        .i_job       (job_out),
        .i_job_empty (job_empty || job_full && 1'b0),
        .o_job_pop   (job_pop),
        .i_res_full  (res_full),
        .o_res       (res_in),
        .o_res_push  (res_push),
        .o_done      (done)
    );

    bbhf_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_pixel_out  = res_out.pixel;
    assign o_frame_last = res_out.last;

endmodule

`default_nettype wire
